@@ rtl/mrfb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus request frame builder package
// Function codes, frame constants, CRC-16/MODBUS byte update and the frame
// record that travels down the pipeline.
// ----------------------------------------------------------------------------
package mrfb_pkg;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [7:0]  FN_READ_HOLDING  = 8'h03;
	localparam logic [7:0]  FN_WRITE_SINGLE  = 8'h06;
	localparam logic [7:0]  FN_WRITE_MULTI   = 8'h10;
	localparam logic [7:0]  MULTI_REG_COUNT  = 8'd2;
	localparam logic [7:0]  MULTI_BYTE_COUNT = 8'(2 * 2);
	localparam logic [15:0] CRC_INIT         = 16'hFFFF;
	localparam logic [15:0] CRC_POLY         = 16'hA001;
	localparam logic [6:0]  COUNT_RESET      = 7'd20;

	// Remaining-beat count loaded at frame start (frame length minus one).
	localparam logic [3:0]  LAST_SHORT = 4'd7;
	localparam logic [3:0]  LAST_LONG  = 4'd12;

	typedef enum logic [1:0] {
		KIND_READ   = 2'd0,
		KIND_WRITE1 = 2'd1,
		KIND_WRITE2 = 2'd2
	} mrfb_kind_t;

	typedef enum logic {
		REG_READ_BASE = 1'b0,
		REG_COUNT     = 1'b1
	} mrfb_reg_t;

	typedef struct packed {
		logic              long_frame;
		logic [15:0]       crc;
		logic [10:0][7:0]  data;
	} mrfb_frame_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
	                                         input logic [7:0] din);
		logic [15:0] c;
		c = crc_in ^ {8'h00, din};
		for (int b = 0; b < 8; b++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ rtl/mrfb_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus request frame builder channels
// Request channel and frame byte channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface mrfb_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  device_address;
	logic [15:0] register_address;
	logic [15:0] value;

	modport source(output valid, kind, device_address, register_address, value,
	               input ready);
	modport sink(input valid, kind, device_address, register_address, value,
	             output ready);
endinterface

interface mrfb_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last;

	modport source(output valid, frame_byte, last, input ready);
	modport sink(input valid, frame_byte, last, output ready);
endinterface

@@ rtl/mrfb_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// APB write/read of the read-frame start address and register count.
// ----------------------------------------------------------------------------
module mrfb_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mrfb_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [mrfb_pkg::APB_DATA_W-1:0] pwdata,
	output logic [mrfb_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output logic [15:0]                    start_addr,
	output logic [6:0]                     reg_count
);

	logic [15:0]       start_addr_q;
	logic [6:0]        reg_count_q;
	logic              wr_en;
	mrfb_pkg::mrfb_reg_t reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = mrfb_pkg::mrfb_reg_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_addr_q <= '0;
			reg_count_q  <= mrfb_pkg::COUNT_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				mrfb_pkg::REG_READ_BASE: start_addr_q <= pwdata[15:0];
				mrfb_pkg::REG_COUNT:     reg_count_q  <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			mrfb_pkg::REG_READ_BASE: prdata = {16'h0000, start_addr_q};
			mrfb_pkg::REG_COUNT:     prdata = {25'h0, reg_count_q};
			default:                 prdata = '0;
		endcase
	end

	assign start_addr = start_addr_q;
	assign reg_count  = reg_count_q;

endmodule

@@ rtl/mrfb_build.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame assembly stage
// Accepts a request and registers the frame body bytes ahead of the CRC.
// ----------------------------------------------------------------------------
module mrfb_build (
	input  logic                  clk,
	input  logic                  arst_n,
	mrfb_req_if.sink              req,
	input  logic [15:0]           start_addr,
	input  logic [6:0]            reg_count,
	output logic                  dn_valid,
	input  logic                  dn_ready,
	output mrfb_pkg::mrfb_frame_t dn_frame
);

	logic                  valid_s1;
	mrfb_pkg::mrfb_frame_t frame_s1;
	mrfb_pkg::mrfb_frame_t body;
	logic                  body_ok;
	logic                  take;

	assign req.ready = !valid_s1 || dn_ready;
	assign take      = req.valid && req.ready;

	always_comb begin
		body            = '0;
		body.crc        = mrfb_pkg::CRC_INIT;
		body.data[0]    = req.device_address;
		body_ok         = 1'b1;
		case (req.kind)
			mrfb_pkg::KIND_READ: begin
				body.data[1] = mrfb_pkg::FN_READ_HOLDING;
				body.data[2] = start_addr[15:8];
				body.data[3] = start_addr[7:0];
				body.data[5] = {1'b0, reg_count};
			end
			mrfb_pkg::KIND_WRITE1: begin
				body.data[1] = mrfb_pkg::FN_WRITE_SINGLE;
				body.data[2] = req.register_address[15:8];
				body.data[3] = req.register_address[7:0];
				body.data[4] = req.value[15:8];
				body.data[5] = req.value[7:0];
			end
			mrfb_pkg::KIND_WRITE2: begin
				body.long_frame = 1'b1;
				body.data[1]    = mrfb_pkg::FN_WRITE_MULTI;
				body.data[2]    = req.register_address[15:8];
				body.data[3]    = req.register_address[7:0];
				body.data[5]    = mrfb_pkg::MULTI_REG_COUNT;
				body.data[6]    = mrfb_pkg::MULTI_BYTE_COUNT;
				body.data[7]    = req.value[15:8];
				body.data[8]    = req.value[7:0];
			end
			// unused kind: swallow the beat, no frame
			default: body_ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= body_ok;
		end else if (dn_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			frame_s1 <= body;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_frame = frame_s1;

endmodule

@@ rtl/mrfb_crc_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC pipeline
// Three stages fold the frame body into CRC-16/MODBUS, up to four bytes each.
// ----------------------------------------------------------------------------
module mrfb_crc_pipe (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  up_valid,
	output logic                  up_ready,
	input  mrfb_pkg::mrfb_frame_t up_frame,
	output logic                  dn_valid,
	input  logic                  dn_ready,
	output mrfb_pkg::mrfb_frame_t dn_frame
);

	logic                  valid_s2, valid_s3, valid_s4;
	mrfb_pkg::mrfb_frame_t frame_s2, frame_s3, frame_s4;
	logic                  rdy_s2, rdy_s3, rdy_s4;
	logic [15:0]           crc2, crc3, crc4;

	assign rdy_s4   = !valid_s4 || dn_ready;
	assign rdy_s3   = !valid_s3 || rdy_s4;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign up_ready = rdy_s2;

	// bytes 0..3 are in every frame
	always_comb begin
		crc2 = up_frame.crc;
		for (int i = 0; i < 4; i++) begin
			crc2 = mrfb_pkg::crc_byte(crc2, up_frame.data[i]);
		end
	end

	// bytes 4..5 always, 6..7 only in the long frame
	always_comb begin
		crc3 = frame_s2.crc;
		for (int i = 4; i < 8; i++) begin
			if (i < 6 || frame_s2.long_frame) begin
				crc3 = mrfb_pkg::crc_byte(crc3, frame_s2.data[i]);
			end
		end
	end

	// bytes 8..10 only in the long frame
	always_comb begin
		crc4 = frame_s3.crc;
		for (int i = 8; i < 11; i++) begin
			if (frame_s3.long_frame) begin
				crc4 = mrfb_pkg::crc_byte(crc4, frame_s3.data[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy_s2) valid_s2 <= up_valid;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && up_valid) begin
			frame_s2 <= '{long_frame: up_frame.long_frame, crc: crc2, data: up_frame.data};
		end
		if (rdy_s3 && valid_s2) begin
			frame_s3 <= '{long_frame: frame_s2.long_frame, crc: crc3, data: frame_s2.data};
		end
		if (rdy_s4 && valid_s3) begin
			frame_s4 <= '{long_frame: frame_s3.long_frame, crc: crc4, data: frame_s3.data};
		end
	end

	assign dn_valid = valid_s4;
	assign dn_frame = frame_s4;

endmodule

@@ rtl/mrfb_ser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame serializer
// Loads a finished frame with its CRC and shifts it out one byte per beat.
// ----------------------------------------------------------------------------
module mrfb_ser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  up_valid,
	output logic                  up_ready,
	input  mrfb_pkg::mrfb_frame_t up_frame,
	mrfb_byte_if.source           frm
);

	logic [12:0][7:0] shift_q;
	logic [12:0][7:0] load_bytes;
	logic [3:0]       left_q;
	logic             busy_q;
	logic             beat;
	logic             last_beat;
	logic             load;

	assign beat      = busy_q && frm.ready;
	assign last_beat = beat && (left_q == 4'd0);
	assign up_ready  = !busy_q || last_beat;
	assign load      = up_valid && up_ready;

	always_comb begin
		load_bytes = '0;
		for (int i = 0; i < 11; i++) begin
			load_bytes[i] = up_frame.data[i];
		end
		// CRC low byte first, right after the body
		if (up_frame.long_frame) begin
			load_bytes[11] = up_frame.crc[7:0];
			load_bytes[12] = up_frame.crc[15:8];
		end else begin
			load_bytes[6] = up_frame.crc[7:0];
			load_bytes[7] = up_frame.crc[15:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			left_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			left_q <= up_frame.long_frame ? mrfb_pkg::LAST_LONG : mrfb_pkg::LAST_SHORT;
		end else if (last_beat) begin
			busy_q <= 1'b0;
		end else if (beat) begin
			left_q <= left_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			shift_q <= load_bytes;
		end else if (beat) begin
			shift_q <= {8'h00, shift_q[12:1]};
		end
	end

	assign frm.valid      = busy_q;
	assign frm.frame_byte = shift_q[0];
	assign frm.last       = left_q == 4'd0;

endmodule

@@ rtl/modbus_request_frame_builder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU request frame builder
// Request in, frame bytes with CRC-16/MODBUS out, APB configuration.
// ----------------------------------------------------------------------------
// Each accepted request becomes a frame of 8 bytes (read holding registers,
// write single register) or 13 bytes (write two registers), sent one byte per
// cycle while the receiver is ready, with last set on the high CRC byte; kind 3
// is taken and dropped. The output serializer sets the rate: it loads the next
// frame on the last byte of the current one, so frames follow each other
// without a gap while requests keep coming. The first byte of a frame is
// presented once the assembly stage and three CRC stages have loaded the
// serializer. Up to five requests are held in flight. Registers sit at byte
// address 0 (read start address) and 4 (read register count). The user must
// write them only while the block is idle; the block does not enforce it.
module modbus_request_frame_builder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mrfb_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [mrfb_pkg::APB_DATA_W-1:0] pwdata,
	output logic [mrfb_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	mrfb_req_if.sink                       req,
	mrfb_byte_if.source                    frm
);

	logic [15:0]           start_addr;
	logic [6:0]            reg_count;
	logic                  b_valid, b_ready;
	mrfb_pkg::mrfb_frame_t b_frame;
	logic                  c_valid, c_ready;
	mrfb_pkg::mrfb_frame_t c_frame;

	mrfb_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.start_addr (start_addr),
		.reg_count  (reg_count)
	);

	mrfb_build u_build (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.start_addr (start_addr),
		.reg_count  (reg_count),
		.dn_valid   (b_valid),
		.dn_ready   (b_ready),
		.dn_frame   (b_frame)
	);

	mrfb_crc_pipe u_crc (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (b_valid),
		.up_ready (b_ready),
		.up_frame (b_frame),
		.dn_valid (c_valid),
		.dn_ready (c_ready),
		.dn_frame (c_frame)
	);

	mrfb_ser u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (c_valid),
		.up_ready (c_ready),
		.up_frame (c_frame),
		.frm      (frm)
	);

endmodule

@@ rtl/mrfb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame builder port checker
// Watches the frame byte channel for stall stability, frame length and function code.
// ----------------------------------------------------------------------------
module mrfb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       frm_valid,
	input logic       frm_ready,
	input logic [7:0] frm_byte,
	input logic       frm_last
);

	logic [3:0] pos_q;
	logic       beat;

	assign beat = frm_valid && frm_ready;

	// position of the next beat within its frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (beat) begin
			pos_q <= frm_last ? 4'd0 : pos_q + 4'd1;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		frm_valid && !frm_ready |=> frm_valid && $stable(frm_byte) && $stable(frm_last))
		else $error("frame beat changed while stalled");

	a_last_len: assert property (@(posedge clk) disable iff (!arst_n)
		beat && frm_last |-> pos_q == mrfb_pkg::LAST_SHORT || pos_q == mrfb_pkg::LAST_LONG)
		else $error("frame ended at a wrong length");

	a_max_len: assert property (@(posedge clk) disable iff (!arst_n)
		beat && !frm_last |-> pos_q < mrfb_pkg::LAST_LONG)
		else $error("frame longer than thirteen bytes");

	a_fn_code: assert property (@(posedge clk) disable iff (!arst_n)
		beat && pos_q == 4'd1 |-> frm_byte == mrfb_pkg::FN_READ_HOLDING ||
			frm_byte == mrfb_pkg::FN_WRITE_SINGLE || frm_byte == mrfb_pkg::FN_WRITE_MULTI)
		else $error("second frame byte is not a known function code");

endmodule

bind modbus_request_frame_builder mrfb_checker u_mrfb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.frm_valid (frm.valid),
	.frm_ready (frm.ready),
	.frm_byte  (frm.frame_byte),
	.frm_last  (frm.last)
);
